/* sv/gwme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_pkg - shared types and constants for the grid wall map engine
// Operation and status codes, wall bit masks, the job record passed from
// the front end to the back end, and the axis step classifier.
// ----------------------------------------------------------------------------
package gwme_pkg;

    localparam int COORD_W = 4;
    localparam int SIZE_W  = 5;
    localparam int WALL_W  = 6;

    localparam logic [WALL_W-1:0] CELL_RESET = 6'd15;

    // Face bits: the wall a cell holds toward its neighbor in each direction
    localparam logic [WALL_W-1:0] WALL_X_NEG = 6'b010000;
    localparam logic [WALL_W-1:0] WALL_X_POS = 6'b000100;
    localparam logic [WALL_W-1:0] WALL_Y_NEG = 6'b000001;
    localparam logic [WALL_W-1:0] WALL_Y_POS = 6'b100000;
    localparam logic [WALL_W-1:0] WALL_Z_NEG = 6'b000010;
    localparam logic [WALL_W-1:0] WALL_Z_POS = 6'b001000;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_BUILD  = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_NOT_ADJ = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        STEP_SAME  = 2'd0,
        STEP_PLUS  = 2'd1,
        STEP_MINUS = 2'd2,
        STEP_FAR   = 2'd3
    } step_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_READ  = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        op_t                op;
        logic [WALL_W-1:0]  mask1;
        logic [WALL_W-1:0]  mask2;
        status_t            status;
    } job_ctl_t;

    // Relation of coordinate b to coordinate a along one axis
    function automatic step_t step_of(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        logic [COORD_W:0] ae;
        logic [COORD_W:0] be;
        step_t            res;
        ae = {1'b0, a};
        be = {1'b0, b};
        priority if (be == ae + (COORD_W+1)'(1))
            res = STEP_PLUS;
        else if (ae == be + (COORD_W+1)'(1))
            res = STEP_MINUS;
        else if (a == b)
            res = STEP_SAME;
        else
            res = STEP_FAR;
        return res;
    endfunction

endpackage

/* sv/gwme_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_front - input stage and request classifier
// Registers one transfer, checks bounds and adjacency, picks the wall bits
// and computes both cell addresses, then pushes a job into the queue.
// ----------------------------------------------------------------------------
module gwme_front #(
    parameter int MAX_X  = 16,
    parameter int MAX_Y  = 16,
    parameter int MAX_Z  = 16,
    parameter int ADDR_W = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clearing,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [gwme_pkg::COORD_W-1:0]   first_x,
    input  logic [gwme_pkg::COORD_W-1:0]   first_y,
    input  logic [gwme_pkg::COORD_W-1:0]   first_z,
    input  logic [gwme_pkg::COORD_W-1:0]   second_x,
    input  logic [gwme_pkg::COORD_W-1:0]   second_y,
    input  logic [gwme_pkg::COORD_W-1:0]   second_z,
    input  logic [$clog2(MAX_X+1)-1:0]     sx,
    input  logic [$clog2(MAX_Y+1)-1:0]     sy,
    input  logic [$clog2(MAX_Z+1)-1:0]     sz,
    input  logic [ADDR_W-1:0]              sxsz,
    input  logic                           q_full,
    output logic                           q_push,
    output gwme_pkg::job_ctl_t             q_ctl,
    output logic [ADDR_W-1:0]              q_addr1,
    output logic [ADDR_W-1:0]              q_addr2
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [1:0]                    op_reg;
    logic [gwme_pkg::COORD_W-1:0]  x1_reg, y1_reg, z1_reg;
    logic [gwme_pkg::COORD_W-1:0]  x2_reg, y2_reg, z2_reg;
    logic                          accept;

    gwme_pkg::step_t               dx, dy, dz;
    logic                          outside;
    logic                          adjacent;
    logic                          mx, my, mz;
    logic [ADDR_W-1:0]             sx_a;

    assign q_push   = valid_reg && !q_full;
    assign in_stall = clearing || (valid_reg && q_full);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= operation;
            x1_reg <= first_x;
            y1_reg <= first_y;
            z1_reg <= first_z;
            x2_reg <= second_x;
            y2_reg <= second_y;
            z2_reg <= second_z;
        end
    end

    // Classification
    always_comb
    begin
        dx = gwme_pkg::step_of(x1_reg, x2_reg);
        dy = gwme_pkg::step_of(y1_reg, y2_reg);
        dz = gwme_pkg::step_of(z1_reg, z2_reg);

        outside = (32'(x1_reg) >= 32'(sx)) || (32'(y1_reg) >= 32'(sy)) ||
                  (32'(z1_reg) >= 32'(sz)) || (32'(x2_reg) >= 32'(sx)) ||
                  (32'(y2_reg) >= 32'(sy)) || (32'(z2_reg) >= 32'(sz));

        mx = (dx == gwme_pkg::STEP_PLUS) || (dx == gwme_pkg::STEP_MINUS);
        my = (dy == gwme_pkg::STEP_PLUS) || (dy == gwme_pkg::STEP_MINUS);
        mz = (dz == gwme_pkg::STEP_PLUS) || (dz == gwme_pkg::STEP_MINUS);

        adjacent = (mx && dy == gwme_pkg::STEP_SAME && dz == gwme_pkg::STEP_SAME) ||
                   (my && dx == gwme_pkg::STEP_SAME && dz == gwme_pkg::STEP_SAME) ||
                   (mz && dx == gwme_pkg::STEP_SAME && dy == gwme_pkg::STEP_SAME);

        priority if (dx == gwme_pkg::STEP_MINUS)
        begin
            q_ctl.mask1 = gwme_pkg::WALL_X_NEG;
            q_ctl.mask2 = gwme_pkg::WALL_X_POS;
        end
        else if (dx == gwme_pkg::STEP_PLUS)
        begin
            q_ctl.mask1 = gwme_pkg::WALL_X_POS;
            q_ctl.mask2 = gwme_pkg::WALL_X_NEG;
        end
        else if (dy == gwme_pkg::STEP_MINUS)
        begin
            q_ctl.mask1 = gwme_pkg::WALL_Y_NEG;
            q_ctl.mask2 = gwme_pkg::WALL_Y_POS;
        end
        else if (dy == gwme_pkg::STEP_PLUS)
        begin
            q_ctl.mask1 = gwme_pkg::WALL_Y_POS;
            q_ctl.mask2 = gwme_pkg::WALL_Y_NEG;
        end
        else if (dz == gwme_pkg::STEP_MINUS)
        begin
            q_ctl.mask1 = gwme_pkg::WALL_Z_NEG;
            q_ctl.mask2 = gwme_pkg::WALL_Z_POS;
        end
        else
        begin
            q_ctl.mask1 = gwme_pkg::WALL_Z_POS;
            q_ctl.mask2 = gwme_pkg::WALL_Z_NEG;
        end

        // Code 3 is treated as a query
        unique case (op_reg)
            gwme_pkg::OP_BUILD:  q_ctl.op = gwme_pkg::OP_BUILD;
            gwme_pkg::OP_REMOVE: q_ctl.op = gwme_pkg::OP_REMOVE;
            default:             q_ctl.op = gwme_pkg::OP_QUERY;
        endcase

        priority if (outside)
            q_ctl.status = gwme_pkg::ST_OUTSIDE;
        else if (!adjacent)
            q_ctl.status = gwme_pkg::ST_NOT_ADJ;
        else
            q_ctl.status = gwme_pkg::ST_DONE;
    end

    // Linear address x + z*sx + y*sx*sz, exact modulo the address width
    assign sx_a    = ADDR_W'(sx);
    assign q_addr1 = ADDR_W'(x1_reg) + ADDR_W'(z1_reg) * sx_a + ADDR_W'(y1_reg) * sxsz;
    assign q_addr2 = ADDR_W'(x2_reg) + ADDR_W'(z2_reg) * sx_a + ADDR_W'(y2_reg) * sxsz;

endmodule

/* sv/gwme_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_queue - two-entry job queue
// Decouples the classifier from the store sequencer.
// ----------------------------------------------------------------------------
module gwme_queue #(
    parameter int ADDR_W = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gwme_pkg::job_ctl_t   push_ctl,
    input  logic [ADDR_W-1:0]    push_addr1,
    input  logic [ADDR_W-1:0]    push_addr2,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output gwme_pkg::job_ctl_t   head_ctl,
    output logic [ADDR_W-1:0]    head_addr1,
    output logic [ADDR_W-1:0]    head_addr2
);

    gwme_pkg::job_ctl_t   ctl_reg   [2];
    logic [ADDR_W-1:0]    addr1_reg [2];
    logic [ADDR_W-1:0]    addr2_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign head_ctl   = ctl_reg[rd_ptr_reg];
    assign head_addr1 = addr1_reg[rd_ptr_reg];
    assign head_addr2 = addr2_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_reg[wr_ptr_reg]   <= push_ctl;
            addr1_reg[wr_ptr_reg] <= push_addr1;
            addr2_reg[wr_ptr_reg] <= push_addr2;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("job queue count out of range");

endmodule

/* sv/gwme_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwme_back - wall store and job sequencer
// Holds the wall store, runs the clearing pass after reset, and executes
// jobs: read both cells, then for a build or remove write the first and defer the second.
// ----------------------------------------------------------------------------
module gwme_back #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 clearing,
    input  logic                 q_valid,
    input  gwme_pkg::job_ctl_t   q_ctl,
    input  logic [ADDR_W-1:0]    q_addr1,
    input  logic [ADDR_W-1:0]    q_addr2,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 passage_open,
    output logic [1:0]           status
);

    localparam int W = gwme_pkg::WALL_W;

    logic [W-1:0]              mem [DEPTH];
    logic [W-1:0]              rd1_reg, rd2_reg;

    gwme_pkg::back_state_t     state_reg, state_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;

    logic                      pw_valid_reg, pw_valid_next;
    logic [ADDR_W-1:0]         pw_addr_reg;
    logic [W-1:0]              pw_data_reg;
    logic                      pw_load;

    gwme_pkg::job_ctl_t        job_ctl_reg;
    logic [ADDR_W-1:0]         job_a1_reg, job_a2_reg;
    logic                      byp1_reg, byp2_reg;
    logic                      job_load;

    logic                      out_valid_reg, out_valid_next;
    logic                      open_reg;
    gwme_pkg::status_t         status_reg;
    logic                      out_load;
    logic                      out_free;
    logic                      res_open;
    gwme_pkg::status_t         res_status;

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [W-1:0]              wr_data;
    logic                      rd_en;

    logic [W-1:0]              data1, data2;
    logic [W-1:0]              new1, new2;

    assign out_free     = !out_valid_reg || !out_stall;
    assign clearing     = (state_reg == gwme_pkg::BK_CLEAR);
    assign out_valid    = out_valid_reg;
    assign passage_open = open_reg;
    assign status       = status_reg;

    // Cell data with bypass of the deferred write that retired as it was read
    assign data1 = byp1_reg ? pw_data_reg : rd1_reg;
    assign data2 = byp2_reg ? pw_data_reg : rd2_reg;

    always_comb
    begin
        unique case (job_ctl_reg.op)
            gwme_pkg::OP_BUILD:
            begin
                new1 = data1 | job_ctl_reg.mask1;
                new2 = data2 | job_ctl_reg.mask2;
            end
            gwme_pkg::OP_REMOVE:
            begin
                new1 = data1 & ~job_ctl_reg.mask1;
                new2 = data2 & ~job_ctl_reg.mask2;
            end
            default:
            begin
                new1 = data1;
                new2 = data2;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pw_valid_next  = pw_valid_reg;
        pw_load        = 1'b0;
        job_load       = 1'b0;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        res_open       = 1'b0;
        res_status     = gwme_pkg::ST_DONE;
        wr_en          = 1'b0;
        wr_addr        = pw_addr_reg;
        wr_data        = pw_data_reg;
        rd_en          = 1'b0;

        unique case (state_reg)
            gwme_pkg::BK_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = gwme_pkg::CELL_RESET;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = gwme_pkg::BK_READ;
            end
            gwme_pkg::BK_READ:
            begin
                // retire the deferred second-cell write
                if (pw_valid_reg)
                begin
                    wr_en         = 1'b1;
                    pw_valid_next = 1'b0;
                end
                if (q_valid)
                begin
                    if (q_ctl.status != gwme_pkg::ST_DONE)
                    begin
                        if (out_free)
                        begin
                            q_pop      = 1'b1;
                            out_load   = 1'b1;
                            res_status = q_ctl.status;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        rd_en      = 1'b1;
                        job_load   = 1'b1;
                        state_next = gwme_pkg::BK_EXEC;
                    end
                end
            end
            gwme_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = gwme_pkg::BK_READ;
                    if (job_ctl_reg.op == gwme_pkg::OP_QUERY)
                        res_open = ((data1 & job_ctl_reg.mask1) == '0) &&
                                   ((data2 & job_ctl_reg.mask2) == '0);
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = job_a1_reg;
                        wr_data       = new1;
                        pw_load       = 1'b1;
                        pw_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = gwme_pkg::BK_READ;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwme_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pw_valid_reg  <= pw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_load)
        begin
            pw_addr_reg <= job_a2_reg;
            pw_data_reg <= new2;
        end
        if (job_load)
        begin
            job_ctl_reg <= q_ctl;
            job_a1_reg  <= q_addr1;
            job_a2_reg  <= q_addr2;
            byp1_reg    <= pw_valid_reg && (pw_addr_reg == q_addr1);
            byp2_reg    <= pw_valid_reg && (pw_addr_reg == q_addr2);
        end
        if (out_load)
        begin
            open_reg   <= res_open;
            status_reg <= res_status;
        end
    end

    // Wall store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd1_reg <= mem[q_addr1];
            rd2_reg <= mem[q_addr2];
        end
    end

    a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg == gwme_pkg::BK_EXEC)
        else $error("store read not followed by execute");

    a_no_pending_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gwme_pkg::BK_EXEC |-> !pw_valid_reg)
        else $error("deferred write still pending in execute");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gwme_pkg::BK_CLEAR |-> !out_valid_reg && !q_pop)
        else $error("job activity during clearing pass");

endmodule

/* sv/grid_wall_map_engine_core.sv */
`timescale 1ns / 1ps
// A flagged request (outside or not adjacent) loads its result from the queue;
//   a store job reads both cells, then executes. The front takes one transfer per cycle
//   unless clearing or the queue is full; the back ends each store job before the next
//   and, while out_stall does not hold the result, retires one flagged job per cycle.
// Reset: size registers return to 3; a clearing pass over all MAX_X*MAX_Y*MAX_Z cells
//   (4096 at default) sets every cell to 15 with in_stall held high.
// ----------------------------------------------------------------------------
// grid_wall_map_engine_core - 3D grid wall map engine, top level
// Configuration port for the grid sizes, a front end that registers and
// classifies each request, a two-entry job queue, and a back end that owns
// the wall store and returns one result per request.
// ----------------------------------------------------------------------------
module grid_wall_map_engine_core #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,

    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [gwme_pkg::COORD_W-1:0]   first_x,
    input  logic [gwme_pkg::COORD_W-1:0]   first_y,
    input  logic [gwme_pkg::COORD_W-1:0]   first_z,
    input  logic [gwme_pkg::COORD_W-1:0]   second_x,
    input  logic [gwme_pkg::COORD_W-1:0]   second_y,
    input  logic [gwme_pkg::COORD_W-1:0]   second_z,

    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           passage_open,
    output logic [1:0]                     status
);

    localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SX_W   = $clog2(MAX_X + 1);
    localparam int SY_W   = $clog2(MAX_Y + 1);
    localparam int SZ_W   = $clog2(MAX_Z + 1);

    // ------------------------------------------------------------------
    // Size registers. Each is 5 bits; values above the build maximum act
    // as that maximum, zero leaves no cell inside the grid.
    // ------------------------------------------------------------------
    logic [gwme_pkg::SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic                         cfg_wr;
    logic [SX_W-1:0]              sx;
    logic [SY_W-1:0]              sy;
    logic [SZ_W-1:0]              sz;
    logic [ADDR_W-1:0]            sxsz_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 5'd3;
            size_y_reg <= 5'd3;
            size_z_reg <= 5'd3;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gwme_pkg::REG_SIZE_X: size_x_reg <= pwdata[gwme_pkg::SIZE_W-1:0];
                gwme_pkg::REG_SIZE_Y: size_y_reg <= pwdata[gwme_pkg::SIZE_W-1:0];
                gwme_pkg::REG_SIZE_Z: size_z_reg <= pwdata[gwme_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gwme_pkg::REG_SIZE_X: prdata = 32'(size_x_reg);
            gwme_pkg::REG_SIZE_Y: prdata = 32'(size_y_reg);
            gwme_pkg::REG_SIZE_Z: prdata = 32'(size_z_reg);
            default:              prdata = '0;
        endcase
    end

    // Effective sizes, clamped to the build maximum
    assign sx = (32'(size_x_reg) > MAX_X) ? SX_W'(MAX_X) : SX_W'(size_x_reg);
    assign sy = (32'(size_y_reg) > MAX_Y) ? SY_W'(MAX_Y) : SY_W'(size_y_reg);
    assign sz = (32'(size_z_reg) > MAX_Z) ? SZ_W'(MAX_Z) : SZ_W'(size_z_reg);

    // Layer stride sx*sz, registered so the address path holds a single
    // multiply per term. The user must change sizes only while idle; the
    // block does not enforce it. Requests are classified from the front input register.
    always_ff @(posedge clk)
    begin
        sxsz_reg <= ADDR_W'(sx) * ADDR_W'(sz);
    end

    // ------------------------------------------------------------------
    // Front end -> queue -> back end
    // ------------------------------------------------------------------
    logic                  clearing;
    logic                  q_full;
    logic                  q_push;
    gwme_pkg::job_ctl_t    push_ctl;
    logic [ADDR_W-1:0]     push_addr1, push_addr2;
    logic                  q_valid;
    logic                  q_pop;
    gwme_pkg::job_ctl_t    head_ctl;
    logic [ADDR_W-1:0]     head_addr1, head_addr2;

    gwme_front #(
        .MAX_X  (MAX_X),
        .MAX_Y  (MAX_Y),
        .MAX_Z  (MAX_Z),
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .sx       (sx),
        .sy       (sy),
        .sz       (sz),
        .sxsz     (sxsz_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctl    (push_ctl),
        .q_addr1  (push_addr1),
        .q_addr2  (push_addr2)
    );

    gwme_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ctl   (push_ctl),
        .push_addr1 (push_addr1),
        .push_addr2 (push_addr2),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_ctl   (head_ctl),
        .head_addr1 (head_addr1),
        .head_addr2 (head_addr2)
    );

    gwme_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_ctl        (head_ctl),
        .q_addr1      (head_addr1),
        .q_addr2      (head_addr2),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .passage_open (passage_open),
        .status       (status)
    );

endmodule
